// ===== rtl/rc4_stream_cipher_core_macros.svh =====
// ----------------------------------------------------------------------------
// rc4 stream cipher core assertion macros
// shared property forms for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RC4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4 package
// widths, opcodes, key byte selection and the engine interface structs
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W         = 8;
    localparam int KEY_W          = 32;
    localparam int KEY_WORD_BYTES = KEY_W / BYTE_W;
    localparam int KEY_BYTES      = 4;
    localparam int KIDX_W         = 3;
    localparam int PERM_DEPTH     = 256;
    localparam int PERM_AW        = $clog2(PERM_DEPTH);

    localparam logic [KIDX_W-1:0]  KIDX_LAST = KIDX_W'(KEY_BYTES - 1);
    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

    localparam logic OP_REKEY = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic              start;
        logic              opcode;
        logic [KEY_W-1:0]  key_word;
        logic [BYTE_W-1:0] data_in;
        logic              out_free;
    } req_t;

    typedef struct packed {
        logic              ready;
        logic              res_valid;
        logic [BYTE_W-1:0] res_data;
        logic              res_no_key;
    } sts_t;

    // key bytes beyond the key word read as zero
    function automatic logic [BYTE_W-1:0] key_byte(
        input logic [KEY_W-1:0]  word,
        input logic [KIDX_W-1:0] idx
    );
        if (idx < KEY_WORD_BYTES)
        begin
            return word[{idx[1:0], 3'b000} +: BYTE_W];
        end
        return '0;
    endfunction

endpackage

// ===== rtl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4 generic ram
// one write port, one read port with registered read data, read-first
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rc4_engine.sv =====
// ----------------------------------------------------------------------------
// rc4 engine
// sequencer around the permutation ram: fill, key schedule and keystream
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_core_macros.svh"

module rc4_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  rc4_pkg::req_t req,
    output rc4_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KA,
        ST_KB,
        ST_KC,
        ST_KFIN,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_NKEY
    } state_t;

    state_t                            state_reg, state_next;
    logic [rc4_pkg::PERM_AW-1:0]       cnt_reg, cnt_next;
    logic [rc4_pkg::BYTE_W-1:0]        i_reg, i_next;
    logic [rc4_pkg::BYTE_W-1:0]        j_reg, j_next;
    logic [rc4_pkg::BYTE_W-1:0]        a_reg, a_next;
    logic [rc4_pkg::BYTE_W-1:0]        sum_reg, sum_next;
    logic [rc4_pkg::BYTE_W-1:0]        data_reg, data_next;
    logic [rc4_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [rc4_pkg::KIDX_W-1:0]        kidx_reg, kidx_next;
    logic                              key_loaded_reg, key_loaded_next;
    logic                              fwd_hit_reg, fwd_hit_next;
    logic [rc4_pkg::BYTE_W-1:0]        fwd_data_reg, fwd_data_next;

    logic                              ram_wr_en;
    logic [rc4_pkg::PERM_AW-1:0]       ram_wr_addr;
    logic [rc4_pkg::BYTE_W-1:0]        ram_wr_data;
    logic                              ram_rd_en;
    logic [rc4_pkg::PERM_AW-1:0]       ram_rd_addr;
    logic [rc4_pkg::BYTE_W-1:0]        ram_rd_data;
    logic [rc4_pkg::BYTE_W-1:0]        rd_val;
    logic [rc4_pkg::BYTE_W-1:0]        ks;
    logic                              take;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // read data with same-cycle write forwarded
    assign rd_val = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    // second swap write is still pending when the keystream byte returns
    assign ks = (sum_reg == j_reg) ? a_reg : rd_val;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        sum_next        = sum_reg;
        data_next       = data_reg;
        key_next        = key_reg;
        kidx_next       = kidx_reg;
        key_loaded_next = key_loaded_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg;
        ram_wr_data = cnt_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_reg;

        sts   = '0;
        take  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                sts.ready = 1'b1;
                take      = req.start;
            end
            ST_FILL:
            begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == rc4_pkg::PERM_LAST)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KA;
                end
            end
            ST_KA:
            begin
                // finish previous swap while fetching the next entry
                ram_wr_en   = (cnt_reg != '0);
                ram_wr_addr = j_reg;
                ram_wr_data = a_reg;
                ram_rd_en   = 1'b1;
                state_next  = ST_KB;
            end
            ST_KB:
            begin
                a_next      = rd_val;
                j_next      = j_reg + rd_val + rc4_pkg::key_byte(key_reg, kidx_reg);
                ram_rd_en   = 1'b1;
                ram_rd_addr = j_next;
                kidx_next   = (kidx_reg == rc4_pkg::KIDX_LAST) ? '0 : kidx_reg + 1'b1;
                state_next  = ST_KC;
            end
            ST_KC:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = rd_val;
                cnt_next    = cnt_reg + 1'b1;
                state_next  = (cnt_reg == rc4_pkg::PERM_LAST) ? ST_KFIN : ST_KA;
            end
            ST_KFIN:
            begin
                ram_wr_en       = 1'b1;
                ram_wr_addr     = j_reg;
                ram_wr_data     = a_reg;
                i_next          = '0;
                j_next          = '0;
                key_loaded_next = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_P1:
            begin
                a_next      = rd_val;
                j_next      = j_reg + rd_val;
                ram_rd_en   = 1'b1;
                ram_rd_addr = j_next;
                state_next  = ST_P2;
            end
            ST_P2:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = i_reg;
                ram_wr_data = rd_val;
                sum_next    = a_reg + rd_val;
                ram_rd_en   = 1'b1;
                ram_rd_addr = sum_next;
                state_next  = ST_P3;
            end
            ST_P3:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = j_reg;
                ram_wr_data = a_reg;
                if (req.out_free)
                begin
                    sts.res_valid = 1'b1;
                    sts.res_data  = data_reg ^ ks;
                    sts.ready     = 1'b1;
                    take          = req.start;
                    state_next    = ST_IDLE;
                end
            end
            ST_NKEY:
            begin
                if (req.out_free)
                begin
                    sts.res_valid  = 1'b1;
                    sts.res_no_key = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            key_next  = req.key_word;
            data_next = req.data_in;
            if (req.opcode == rc4_pkg::OP_REKEY)
            begin
                cnt_next   = '0;
                state_next = ST_FILL;
            end
            else if (key_loaded_reg)
            begin
                i_next      = i_reg + 1'b1;
                ram_rd_en   = 1'b1;
                ram_rd_addr = i_next;
                state_next  = ST_P1;
            end
            else
            begin
                state_next = ST_NKEY;
            end
        end

        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (ram_rd_en)
        begin
            fwd_hit_next  = ram_wr_en && (ram_wr_addr == ram_rd_addr);
            fwd_data_next = ram_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            a_reg          <= '0;
            sum_reg        <= '0;
            data_reg       <= '0;
            key_reg        <= '0;
            kidx_reg       <= '0;
            key_loaded_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            fwd_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            a_reg          <= a_next;
            sum_reg        <= sum_next;
            data_reg       <= data_next;
            key_reg        <= key_next;
            kidx_reg       <= kidx_next;
            key_loaded_reg <= key_loaded_next;
            fwd_hit_reg    <= fwd_hit_next;
            fwd_data_reg   <= fwd_data_next;
        end
    end

    `RC4_ASSERT_SAME(a_res_slot_free, clk, rst_n, sts.res_valid, req.out_free,
        "result issued while output slot occupied")
    `RC4_ASSERT_SAME(a_no_key_flag, clk, rst_n, sts.res_valid && sts.res_no_key,
        !key_loaded_reg && (sts.res_data == '0), "no-key word with key loaded or data")
    `RC4_ASSERT_NEXT(a_p1_to_p2, clk, rst_n, state_reg == ST_P1, state_reg == ST_P2,
        "keystream step left second read")
    `RC4_ASSERT_NEXT(a_sched_done, clk, rst_n, state_reg == ST_KFIN,
        key_loaded_reg && (i_reg == '0) && (j_reg == '0), "key schedule end state wrong")
    `RC4_ASSERT_NEXT(a_p3_hold, clk, rst_n, (state_reg == ST_P3) && !req.out_free,
        state_reg == ST_P3, "keystream result dropped under stall")

endmodule

// ===== rtl/rc4_stream_cipher_core.sv =====
// path: a data word runs through P1, P2 and P3, a no-key word through NKEY, then the output
// register; the next word is taken in P3 at the earliest, as the two swap writes share the ram
// write port; rekey fills every entry, runs KA, KB, KC per schedule step, then writes in KFIN
// reset: asynchronous, clears indices, key-loaded flag and handshake state
// the permutation ram is not cleared; it is filled by every rekey
// ----------------------------------------------------------------------------
// rc4 stream cipher core
// valid/stall wrapper with output register around the rc4 engine
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [rc4_pkg::KEY_W-1:0]    key_word,
    input  logic [rc4_pkg::BYTE_W-1:0]   data_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]   data_out,
    output logic                         no_key
);

    rc4_pkg::req_t              req;
    rc4_pkg::sts_t              sts;
    logic                       out_valid_reg, out_valid_next;
    logic [rc4_pkg::BYTE_W-1:0] data_out_reg, data_out_next;
    logic                       no_key_reg, no_key_next;

    rc4_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .sts   (sts)
    );

    always_comb
    begin
        req.start    = in_valid && sts.ready;
        req.opcode   = opcode;
        req.key_word = key_word;
        req.data_in  = data_in;
        req.out_free = !out_valid_reg || !out_stall;

        out_valid_next = out_valid_reg && out_stall;
        data_out_next  = data_out_reg;
        no_key_next    = no_key_reg;
        if (sts.res_valid)
        begin
            out_valid_next = 1'b1;
            data_out_next  = sts.res_data;
            no_key_next    = sts.res_no_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            data_out_reg  <= '0;
            no_key_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            data_out_reg  <= data_out_next;
            no_key_reg    <= no_key_next;
        end
    end

    assign in_stall  = !sts.ready;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign no_key    = no_key_reg;

endmodule
